// File: hdl/key_integrator_debounce_defines.svh
// Assertion macros used by the key debouncer top level.
`ifndef KEY_INTEGRATOR_DEBOUNCE_DEFINES_SVH
`define KEY_INTEGRATOR_DEBOUNCE_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define KID_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define KID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/kid_pkg.sv
// Types and constants shared by the key debouncer modules.
package kid_pkg;

   localparam int KEY_W = 7;
   localparam int LEVEL_W = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [LEVEL_W-1:0] PRESS_LEVEL_RESET = 8'hC0;
   localparam logic [LEVEL_W-1:0] RELEASE_LEVEL_RESET = 8'h04;
   localparam logic [LEVEL_W-1:0] HOLDOFF_COUNT_RESET = 8'd15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESS_LEVEL   = 2'd0,
      CSR_RELEASE_LEVEL = 2'd1,
      CSR_HOLDOFF_COUNT = 2'd2
   } kid_csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] press_level;
      logic [LEVEL_W-1:0] release_level;
      logic [LEVEL_W-1:0] holdoff_count;
   } kid_cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             raw;
      logic             in_range;
   } kid_item_type;

   typedef struct packed {
      logic               stable;
      logic [LEVEL_W-1:0] counter;
      logic [LEVEL_W-1:0] history;
   } kid_entry_type;

   typedef struct packed {
      logic             state_changed;
      logic             key_down;
      logic [KEY_W-1:0] key_number;
   } kid_result_type;

endpackage

// File: hdl/key_integrator_debounce.sv
// Top level of the per-key integrating debouncer.
//
// Each request on req_ carries one raw sample for one key; each sample
// yields exactly one response on rsp_ with the key's debounced state and
// a flag that tells whether that state changed with this sample.
// Thresholds and holdoff are written through csr_, which is always ready.
// Requests move through three register stages: input capture, state memory
// read and update, and the output register. A response is presented once its
// request has passed all three; one request can be accepted every cycle while
// rsp_tready stays high and no clearing sweep runs. The single read and write
// port of the state memory, with write-data forwarding, sets that rate.
// After reset, a sweep clears the state memory one key per cycle, and
// req_tready stays low until the sweep ends.
// When rsp_tready is low, the stages ahead of the output fill up one by one
// and req_tready falls only when every stage is occupied.
`include "key_integrator_debounce_defines.svh"

module key_integrator_debounce #(
   parameter int KEY_COUNT = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // key_index[6:0], raw_pressed[7]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,   // key_number[6:0], key_down[7],
                                                    // state_changed[8], zero[15:9]
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [kid_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kid_pkg::LEVEL_W-1:0]     csr_data
);
   import kid_pkg::*;

   kid_cfg_type    cfg_ff;
   kid_cfg_type    cfg_in;
   kid_item_type   s1_item;
   kid_result_type s2_result;
   kid_result_type rsp_result;
   logic           s1_ready;
   logic           s1_valid;
   logic           s2_ready;
   logic           s2_valid;
   logic           s3_ready;
   logic           clearing;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESS_LEVEL:   cfg_in.press_level = csr_data;
            CSR_RELEASE_LEVEL: cfg_in.release_level = csr_data;
            CSR_HOLDOFF_COUNT: cfg_in.holdoff_count = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_level <= PRESS_LEVEL_RESET;
         cfg_ff.release_level <= RELEASE_LEVEL_RESET;
         cfg_ff.holdoff_count <= HOLDOFF_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = s1_ready && !clearing;

   kid_input_stage #(
      .KEY_COUNT(KEY_COUNT)
   ) u_input (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid && !clearing),
      .in_ready (s1_ready),
      .in_key   (req_tdata[KEY_W-1:0]),
      .in_raw   (req_tdata[KEY_W]),
      .out_valid(s1_valid),
      .out_ready(s2_ready),
      .out_item (s1_item)
   );

   kid_state_stage #(
      .KEY_COUNT(KEY_COUNT)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .in_item   (s1_item),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_result(s2_result),
      .clearing  (clearing)
   );

   kid_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s3_ready),
      .in_result (s2_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_result(rsp_result)
   );

   assign rsp_tdata = {7'd0, rsp_result.state_changed, rsp_result.key_down,
                       rsp_result.key_number};

   `KID_ASSERT_SAME(a_no_request_while_clearing, clearing, !req_tready,
                    "request accepted during the clearing sweep")
   `KID_ASSERT_SAME(a_out_of_range_quiet,
                    rsp_tvalid && int'(rsp_result.key_number) >= KEY_COUNT,
                    !rsp_result.key_down && !rsp_result.state_changed,
                    "key beyond range reported a pressed or changed state")
   `KID_ASSERT_NEXT(a_update_stage_holds, rsp_tvalid && !rsp_tready && s2_valid,
                    s2_valid, "update stage dropped a request under stall")

endmodule

// File: hdl/kid_input_stage.sv
// Input register stage: captures a request and checks its key range.
module kid_input_stage #(
   parameter int KEY_COUNT = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [kid_pkg::KEY_W-1:0] in_key,
   input  logic                    in_raw,
   output logic                    out_valid,
   input  logic                    out_ready,
   output kid_pkg::kid_item_type   out_item
);
   import kid_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   kid_item_type item_ff;
   kid_item_type item_in;
   logic         load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      item_in = item_ff;
      if (load) begin
         item_in.key = in_key;
         item_in.raw = in_raw;
         item_in.in_range = int'(in_key) < KEY_COUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

// File: hdl/kid_state_stage.sv
// Per-key state memory with clearing sweep and the debounce update.
module kid_state_stage #(
   parameter int KEY_COUNT = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  kid_pkg::kid_cfg_type    cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  kid_pkg::kid_item_type   in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output kid_pkg::kid_result_type out_result,
   output logic                    clearing
);
   import kid_pkg::*;

   localparam int ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   kid_entry_type mem [KEY_COUNT];

   logic              valid_ff;
   logic              valid_in;
   kid_item_type      item_ff;
   kid_entry_type     state_ff;
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   logic              load;
   logic              advance;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   kid_entry_type     wr_data;
   logic [ADDR_W-1:0] rd_addr;
   kid_entry_type     next_state;
   logic [LEVEL_W-1:0] hist;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;
   assign advance = valid_ff && out_ready;
   assign rd_addr = ADDR_W'(in_item.key);

   always_comb begin
      hist = {item_ff.raw, state_ff.history[LEVEL_W-1:1]};
      next_state = state_ff;
      next_state.history = hist;
      if (state_ff.counter != '0 && !state_ff.stable) begin
         next_state.counter = state_ff.counter - 1'b1;
      end else if (hist >= cfg.press_level) begin
         next_state.stable = 1'b1;
         next_state.counter = cfg.holdoff_count;
      end else if (hist < cfg.release_level) begin
         next_state.stable = 1'b0;
      end
   end

   always_comb begin
      out_result.key_number = item_ff.key;
      out_result.key_down = item_ff.in_range && next_state.stable;
      out_result.state_changed = item_ff.in_range && (next_state.stable != state_ff.stable);
   end

   always_comb begin
      if (clr_busy_ff) begin
         wr_en = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en = advance && item_ff.in_range;
         wr_addr = ADDR_W'(item_ff.key);
         wr_data = next_state;
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(KEY_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A key written back in this cycle is taken from the write data.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
         if (wr_en && wr_addr == rd_addr) begin
            state_ff <= wr_data;
         end else begin
            state_ff <= mem[rd_addr];
         end
      end
   end

   assign out_valid = valid_ff;
   assign clearing = clr_busy_ff;

endmodule

// File: hdl/kid_output_stage.sv
// Output register stage holding one finished result.
module kid_output_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  kid_pkg::kid_result_type in_result,
   output logic                    out_valid,
   input  logic                    out_ready,
   output kid_pkg::kid_result_type out_result
);
   import kid_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   kid_result_type result_ff;
   kid_result_type result_in;
   logic           load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      result_in = load ? in_result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid = valid_ff;
   assign out_result = result_ff;

endmodule

// File: bench/tb_key_integrator_debounce.sv
// Self-checking testbench for the per-key integrating debouncer.
`timescale 1ns / 1ps

module tb_key_integrator_debounce;
   import kid_pkg::*;

   localparam int KEY_COUNT = 128;
   localparam int PIPE_LATENCY = 3;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_ITEMS = 180;
   localparam int POOL_SIZE = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_CSR
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type          kind;
      logic [KEY_W-1:0]       key;
      logic                   raw;
      logic                   typed;
      logic                   down;
      logic                   changed;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [LEVEL_W-1:0]     value;
   } plan_row_type;

   localparam int PLAN_ROWS = 31;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_SAMPLE, 7'd0,   1'b1, 1'b1, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b1, 1'b1, 1'b1, 1'b1, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b1, 1'b1, 1'b1, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd127, 1'b1, 1'b1, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b0, 1'b1, 1'b0, 1'b1, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd127, 1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_CSR,    7'd0,   1'b0, 1'b0, 1'b0, 1'b0, CSR_PRESS_LEVEL,   8'h00},
      '{ROW_CSR,    7'd0,   1'b0, 1'b0, 1'b0, 1'b0, CSR_RELEASE_LEVEL, 8'hFF},
      '{ROW_CSR,    7'd0,   1'b0, 1'b0, 1'b0, 1'b0, CSR_HOLDOFF_COUNT, 8'h00},
      '{ROW_CSR,    7'd0,   1'b0, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h55},
      '{ROW_SAMPLE, 7'd5,   1'b0, 1'b1, 1'b1, 1'b1, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd0,   1'b0, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_CSR,    7'd0,   1'b0, 1'b0, 1'b0, 1'b0, CSR_PRESS_LEVEL,   8'hFF},
      '{ROW_CSR,    7'd0,   1'b0, 1'b0, 1'b0, 1'b0, CSR_RELEASE_LEVEL, 8'h00},
      '{ROW_SAMPLE, 7'd5,   1'b1, 1'b1, 1'b1, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00},
      '{ROW_SAMPLE, 7'd9,   1'b1, 1'b0, 1'b0, 1'b0, CSR_SPARE_INDEX,   8'h00}
   };

   localparam int FIXED_SETTINGS = 4;
   localparam kid_cfg_type THRESHOLD_SETS [FIXED_SETTINGS] = '{
      '{PRESS_LEVEL_RESET, RELEASE_LEVEL_RESET, HOLDOFF_COUNT_RESET},
      '{8'd128, 8'd64, 8'd3},
      '{8'hFF, 8'h00, 8'h00},
      '{8'h00, 8'hFF, 8'hFF}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // key_index[6:0], raw_pressed[7]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;        // key_number[6:0], key_down[7],
                                             // state_changed[8], zero[15:9]
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LEVEL_W-1:0]     csr_data = '0;

   kid_cfg_type          shadow_cfg;
   logic [LEVEL_W-1:0]   key_history [KEY_COUNT];
   logic [LEVEL_W-1:0]   key_holdoff [KEY_COUNT];
   logic                 key_pressed [KEY_COUNT];
   kid_result_type       pending_results [$];
   int                   error_count = 0;
   int                   idle_cycles = 0;
   bit                   quiet = 1'b0;

   key_integrator_debounce #(
      .KEY_COUNT (KEY_COUNT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic kid_result_type debounce_key(input logic [KEY_W-1:0] key,
                                                   input logic raw);
      kid_result_type     res;
      logic               was_down;
      logic [LEVEL_W-1:0] hist;
      was_down = key_pressed[key];
      hist = {raw, key_history[key][LEVEL_W-1:1]};
      key_history[key] = hist;
      res.key_number = key;
      res.key_down = was_down;
      if (key_holdoff[key] != 0 && !was_down) begin
         key_holdoff[key] = key_holdoff[key] - 1'b1;
      end else if (hist >= shadow_cfg.press_level) begin
         res.key_down = 1'b1;
         key_holdoff[key] = shadow_cfg.holdoff_count;
      end else if (hist < shadow_cfg.release_level) begin
         res.key_down = 1'b0;
      end
      key_pressed[key] = res.key_down;
      res.state_changed = (res.key_down != was_down);
      return res;
   endfunction

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic drain();
      hold_off(1);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 1) @(negedge clock);
   endtask

   task automatic send_sample(input logic [KEY_W-1:0] key, input logic raw,
                              input bit typed, input logic down, input logic changed);
      kid_result_type res;
      if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 16));
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {raw, key};
      do @(posedge clock); while (!req_tready);
      res = debounce_key(key, raw);
      if (typed) begin
         res.key_down = down;
         res.state_changed = changed;
      end
      pending_results.push_back(res);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [LEVEL_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_PRESS_LEVEL:   shadow_cfg.press_level = value;
         CSR_RELEASE_LEVEL: shadow_cfg.release_level = value;
         CSR_HOLDOFF_COUNT: shadow_cfg.holdoff_count = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_thresholds(input kid_cfg_type cfg);
      write_csr(CSR_PRESS_LEVEL, cfg.press_level);
      write_csr(CSR_RELEASE_LEVEL, cfg.release_level);
      write_csr(CSR_HOLDOFF_COUNT, cfg.holdoff_count);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      kid_result_type got;
      kid_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[8:0];
         if (pending_results.size() == 0) begin
            $error("response for key %0d with no request outstanding", got.key_number);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.key_number != want.key_number) begin
               $error("key_number mismatch: expected %0d, actual %0d",
                      want.key_number, got.key_number);
               error_count++;
            end
            if (got.key_down != want.key_down) begin
               $error("key_down mismatch: expected %0b, actual %0b",
                      want.key_down, got.key_down);
               error_count++;
            end
            if (got.state_changed != want.state_changed) begin
               $error("state_changed mismatch: expected %0b, actual %0b",
                      want.state_changed, got.state_changed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      logic [KEY_W-1:0] pool_key [POOL_SIZE];
      logic             pool_level [POOL_SIZE];
      logic [KEY_W-1:0] key;
      logic             raw;
      int               slot;
      kid_cfg_type      cfg;
      shadow_cfg = '{PRESS_LEVEL_RESET, RELEASE_LEVEL_RESET, HOLDOFF_COUNT_RESET};
      for (int k = 0; k < KEY_COUNT; k++) begin
         key_history[k] = '0;
         key_holdoff[k] = '0;
         key_pressed[k] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[r]) begin
         if (DIRECTED_PLAN[r].kind == ROW_CSR) begin
            write_csr(DIRECTED_PLAN[r].reg_index, DIRECTED_PLAN[r].value);
         end else begin
            send_sample(DIRECTED_PLAN[r].key, DIRECTED_PLAN[r].raw, DIRECTED_PLAN[r].typed,
                        DIRECTED_PLAN[r].down, DIRECTED_PLAN[r].changed);
         end
      end

      for (int phase = 0; phase <= FIXED_SETTINGS; phase++) begin
         if (phase < FIXED_SETTINGS) begin
            cfg = THRESHOLD_SETS[phase];
         end else begin
            cfg.press_level = LEVEL_W'($urandom_range(0, 255));
            cfg.release_level = LEVEL_W'($urandom_range(0, 255));
            cfg.holdoff_count = LEVEL_W'($urandom_range(0, 20));
         end
         apply_thresholds(cfg);
         quiet = (phase == FIXED_SETTINGS);
         for (int s = 0; s < POOL_SIZE; s++) begin
            pool_key[s] = KEY_W'($urandom_range(0, KEY_COUNT - 1));
            pool_level[s] = 1'($urandom_range(0, 1));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Sender holds off once until the pipeline has fully drained.
            if (phase == 1 && n == PHASE_ITEMS / 2) drain();
            if ($urandom_range(0, 7) == 0) begin
               key = KEY_W'($urandom_range(0, KEY_COUNT - 1));
               raw = 1'($urandom_range(0, 1));
            end else begin
               slot = $urandom_range(0, POOL_SIZE - 1);
               if ($urandom_range(0, 11) == 0) pool_level[slot] = !pool_level[slot];
               key = pool_key[slot];
               raw = pool_level[slot] ^ ($urandom_range(0, 9) == 0);
            end
            send_sample(key, raw, 1'b0, 1'b0, 1'b0);
         end
      end

      drain();
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/kid_pkg.sv
hdl/kid_input_stage.sv
hdl/kid_state_stage.sv
hdl/kid_output_stage.sv
hdl/key_integrator_debounce.sv
bench/tb_key_integrator_debounce.sv
